// File: hw/rtl/opfb_pkg.sv
// Shared types and constants for the OLED page frame buffer.
package opfb_pkg;

  // Input command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Panel page-address command prefix and fixed column-address commands
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LO_CMD    = 8'h00;
  localparam logic [7:0] COL_HI_CMD    = 8'h10;
  localparam int         HEAD_BYTES    = 3;

  // Queue between decode and execute
  localparam int QUEUE_DEPTH = 2;

  // Widest column address and bit position over the supported panel sizes
  localparam int COL_BITS = 8;
  localparam int POS_BITS = 7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DRAW,
    OP_CLEAR,
    OP_START,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [COL_BITS-1:0] col;
    logic [POS_BITS-1:0] bit_pos;
    logic                dot;
  } fb_item_t;

endpackage

// File: hw/rtl/opfb_front.sv
// Front end: decodes commands and checks draw coordinates against the panel.
module opfb_front
  import opfb_pkg::*;
#(
  parameter int PANEL_COLUMNS = 128,
  parameter int PANEL_PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       dot,
  output logic       push,
  output fb_item_t   push_item,
  input  logic       q_full
);

  logic       x_ok;
  logic       y_ok;
  logic [4:0] page;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign x_ok = ({1'b0, x} < 9'(PANEL_COLUMNS));
  assign y_ok = ({1'b0, y} < 9'(PANEL_PAGES * 8));
  // rows count up from the bottom page; bit 7 is the bottom row of a page
  assign page = 5'(PANEL_PAGES - 1) - y[7:3];

  always_comb begin
    push_item.col     = x;
    push_item.bit_pos = {page[3:0], ~y[2:0]};
    push_item.dot     = dot;
    case (cmd)
      CMD_DRAW:  push_item.op = (x_ok && y_ok) ? OP_DRAW : OP_NOP;
      CMD_CLEAR: push_item.op = OP_CLEAR;
      CMD_START: push_item.op = OP_START;
      CMD_TICK:  push_item.op = OP_TICK;
      default:   push_item.op = OP_NOP;
    endcase
  end

`ifndef SYNTH
  a_ready_tracks_queue: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push while queue full");
  a_off_panel_dropped: assert property (@(posedge clk) disable iff (rst)
    (push && cmd == CMD_DRAW && !x_ok) |-> (push_item.op == OP_NOP))
    else $error("off-panel draw not dropped");
  a_tick_kept: assert property (@(posedge clk) disable iff (rst)
    (push && cmd == CMD_TICK) |-> (push_item.op == OP_TICK))
    else $error("tick misclassified");
`endif

endmodule

// File: hw/rtl/opfb_queue.sv
// Short FIFO of decoded items between front and back end.
module opfb_queue
  import opfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fb_item_t push_item,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output fb_item_t head_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  fb_item_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full       = (count == CNTW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> !pop)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(QUEUE_DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: hw/rtl/opfb_back.sv
// Back end: frame store, refresh sequencer and result register.
module opfb_back
  import opfb_pkg::*;
#(
  parameter int PANEL_COLUMNS = 128,
  parameter int PANEL_PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  fb_item_t   q_item,
  output logic       q_pop,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       frame_last,
  output logic       busy_res
);

  localparam int RW   = PANEL_PAGES * 8;
  localparam int BW   = $clog2(RW);
  localparam int CW   = (PANEL_COLUMNS > 1) ? $clog2(PANEL_COLUMNS) : 1;
  localparam int PSW  = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
  localparam int SLW  = $clog2(PANEL_COLUMNS + HEAD_BYTES);

  // one row per column, all pages of that column side by side
  logic [RW-1:0]        mem [PANEL_COLUMNS];
  logic [PANEL_COLUMNS-1:0] row_ok;

  logic [PSW-1:0] refresh_page, refresh_page_next;
  logic [SLW-1:0] refresh_slot, refresh_slot_next;
  logic           refresh_active, refresh_active_next;

  logic           emit_next, is_data_next, last_next;
  logic [7:0]     cmd_byte, cmd_byte_next;
  logic [PSW-1:0] rd_page;
  logic [RW-1:0]  rdata;
  logic           rd_ok;

  logic           mem_we, mem_re, clear_rows;
  logic [CW-1:0]  waddr, raddr;
  logic [RW-1:0]  wmask, wdata, onehot;

  assign q_pop  = q_valid && (!res_valid || res_ready);
  assign waddr  = q_item.col[CW-1:0];
  assign onehot = RW'(1) << q_item.bit_pos[BW-1:0];
  // a row not written since clear reads as zero, so the first draw fills it
  assign wmask  = row_ok[waddr] ? onehot : '1;
  assign wdata  = q_item.dot ? onehot : '0;
  assign raddr  = CW'(refresh_slot - SLW'(HEAD_BYTES));

  always_comb begin
    refresh_page_next   = refresh_page;
    refresh_slot_next   = refresh_slot;
    refresh_active_next = refresh_active;
    emit_next           = 1'b0;
    is_data_next        = 1'b0;
    last_next           = 1'b0;
    cmd_byte_next       = '0;
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    clear_rows          = 1'b0;
    if (q_pop) begin
      case (q_item.op)
        OP_DRAW:  mem_we = 1'b1;
        OP_CLEAR: clear_rows = 1'b1;
        OP_START: begin
          refresh_active_next = 1'b1;
          refresh_page_next   = '0;
          refresh_slot_next   = '0;
        end
        OP_TICK: begin
          if (refresh_active) begin
            emit_next = 1'b1;
            if (refresh_slot == SLW'(0)) begin
              cmd_byte_next = PAGE_CMD_BASE + 8'(refresh_page);
            end else if (refresh_slot == SLW'(1)) begin
              cmd_byte_next = COL_LO_CMD;
            end else if (refresh_slot == SLW'(2)) begin
              cmd_byte_next = COL_HI_CMD;
            end else begin
              is_data_next = 1'b1;
              mem_re       = 1'b1;
            end
            if (refresh_slot == SLW'(PANEL_COLUMNS + HEAD_BYTES - 1)) begin
              refresh_slot_next = '0;
              if (refresh_page == PSW'(PANEL_PAGES - 1)) begin
                last_next           = 1'b1;
                refresh_page_next   = '0;
                refresh_active_next = 1'b0;
              end else begin
                refresh_page_next = refresh_page + 1'b1;
              end
            end else begin
              refresh_slot_next = refresh_slot + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < RW; i++) begin
        if (wmask[i]) begin
          mem[waddr][i] <= wdata[i];
        end
      end
    end
    if (mem_re) begin
      rdata <= mem[raddr];
      rd_ok <= row_ok[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok         <= '0;
      refresh_page   <= '0;
      refresh_slot   <= '0;
      refresh_active <= 1'b0;
      res_valid      <= 1'b0;
      out_valid      <= 1'b0;
      is_data        <= 1'b0;
      frame_last     <= 1'b0;
      busy_res       <= 1'b0;
    end else begin
      if (clear_rows) begin
        row_ok <= '0;
      end else if (mem_we) begin
        row_ok[waddr] <= 1'b1;
      end
      refresh_page   <= refresh_page_next;
      refresh_slot   <= refresh_slot_next;
      refresh_active <= refresh_active_next;
      if (q_pop) begin
        res_valid  <= 1'b1;
        out_valid  <= emit_next;
        is_data    <= is_data_next;
        frame_last <= last_next;
        busy_res   <= refresh_active_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_byte <= cmd_byte_next;
      rd_page  <= refresh_page;
    end
  end

  assign out_byte = !is_data ? cmd_byte :
                    rd_ok    ? rdata[{rd_page, 3'b000} +: 8] : 8'h00;

`ifndef SYNTH
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear_rows |=> (row_ok == '0))
    else $error("clear left rows valid");
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    !refresh_active |-> (refresh_slot == '0 && refresh_page == '0))
    else $error("refresh counters not parked");
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    refresh_slot < SLW'(PANEL_COLUMNS + HEAD_BYTES))
    else $error("refresh slot out of range");
  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_last) |-> (!busy_res && out_valid && is_data))
    else $error("final byte flags inconsistent");
`endif

endmodule

// File: hw/rtl/oled_page_frame_buffer_top.sv
// Top level of the OLED page frame buffer: decode, queue and execute.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  in       | in_valid/in_ready   | cmd, x, y, dot
//  result   | res_valid/res_ready | out_valid, out_byte, is_data, frame_last, busy_res
//
//  Every accepted transaction gives exactly one result transaction.
//  Sustained rate is one transaction per cycle for every command while the
//  result side keeps res_ready high; an accepted item is written into the queue,
//  then the execute stage loads it into the result register.
//  Clear drops the per-column row-valid flags; there is no store sweep.
//  Reset clears the flags and the sequencer at once; no clearing pass.
//  A stalled result stops the execute stage; the two-entry queue keeps
//  taking input until it fills.
module oled_page_frame_buffer_top
  import opfb_pkg::*;
#(
  parameter int PANEL_COLUMNS = 128,
  parameter int PANEL_PAGES   = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       dot,
  output logic       res_valid,
  input  logic       res_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       frame_last,
  output logic       busy_res
);

  // decoded transaction into the queue
  logic     push;
  fb_item_t push_item;
  logic     q_full;

  // queue head to the execute stage
  logic     q_valid;
  logic     q_pop;
  fb_item_t q_item;

  // classify: off-panel draws become no-ops here
  opfb_front #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .PANEL_PAGES  (PANEL_PAGES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .x        (x),
    .y        (y),
    .dot      (dot),
    .push     (push),
    .push_item(push_item),
    .q_full   (q_full)
  );

  opfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_item (q_item)
  );

  // store writes, refresh sequencing and the result register
  opfb_back #(
    .PANEL_COLUMNS(PANEL_COLUMNS),
    .PANEL_PAGES  (PANEL_PAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .frame_last(frame_last),
    .busy_res  (busy_res)
  );

endmodule

// File: verif/opfb_check_pkg.sv
// Scoreboard class for the OLED page frame buffer: image model, byte prediction and compare.
package opfb_check_pkg;
  import opfb_pkg::*;

  localparam int PANEL_COLS       = 128;
  localparam int PANEL_PAGE_COUNT = 8;

  typedef struct packed {
    logic       emit;
    logic [7:0] pbyte;
    logic       data;
    logic       last;
    logic       busy;
  } panel_out_t;

  class oled_byte_tracker;
    logic [7:0]  image [PANEL_COLS*PANEL_PAGE_COUNT];
    int unsigned dump_page;
    int unsigned dump_slot;
    bit          refresh_on;
    panel_out_t  pending_bytes[$];
    int unsigned mismatches;
    int unsigned cmd_count [4];
    int unsigned draws_off_panel;
    int unsigned bytes_seen;
    int unsigned data_seen;
    int unsigned frames_done;

    function new();
      foreach (image[i]) image[i] = '0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      dump_page       = 0;
      dump_slot       = 0;
      refresh_on      = 1'b0;
      mismatches      = 0;
      draws_off_panel = 0;
      bytes_seen      = 0;
      data_seen       = 0;
      frames_done     = 0;
    endfunction

    // accepted command: update the image/sequencer, queue the byte it yields
    function void apply_command(input logic [1:0] c, input logic [7:0] px,
                                input logic [7:0] py, input logic pdot);
      panel_out_t want;
      int         col_i;
      int         row_i;
      int         idx;
      want  = '0;
      col_i = int'(px);
      row_i = int'(py);
      cmd_count[c]++;
      case (c)
        CMD_DRAW: begin
          if (col_i < PANEL_COLS && row_i < 8 * PANEL_PAGE_COUNT) begin
            idx = col_i * PANEL_PAGE_COUNT + (PANEL_PAGE_COUNT - 1 - row_i / 8);
            image[idx][7 - (row_i % 8)] = pdot;
          end else begin
            draws_off_panel++;
          end
        end
        CMD_CLEAR: begin
          foreach (image[i]) image[i] = '0;
        end
        CMD_START: begin
          refresh_on = 1'b1;
          dump_page  = 0;
          dump_slot  = 0;
        end
        default: begin
          if (refresh_on) begin
            want.emit = 1'b1;
            if (dump_slot == 0) begin
              want.pbyte = PAGE_CMD_BASE + 8'(dump_page);
            end else if (dump_slot == 1) begin
              want.pbyte = COL_LO_CMD;
            end else if (dump_slot == 2) begin
              want.pbyte = COL_HI_CMD;
            end else begin
              want.pbyte = image[(dump_slot - HEAD_BYTES) * PANEL_PAGE_COUNT + dump_page];
              want.data  = 1'b1;
            end
            if (dump_slot + 1 >= HEAD_BYTES + PANEL_COLS) begin
              dump_slot = 0;
              if (dump_page + 1 >= PANEL_PAGE_COUNT) begin
                want.last  = 1'b1;
                dump_page  = 0;
                refresh_on = 1'b0;
              end else begin
                dump_page++;
              end
            end else begin
              dump_slot++;
            end
          end
        end
      endcase
      want.busy = refresh_on;
      pending_bytes.push_back(want);
    endfunction

    function void check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_panel_byte(input logic emit, input logic [7:0] pbyte,
                                   input logic data, input logic last, input logic busy);
      panel_out_t want;
      if (pending_bytes.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      check_field("out_valid", 8'(want.emit), 8'(emit));
      check_field("out_byte", want.pbyte, pbyte);
      check_field("is_data", 8'(want.data), 8'(data));
      check_field("frame_last", 8'(want.last), 8'(last));
      check_field("busy_res", 8'(want.busy), 8'(busy));
      if (want.emit) bytes_seen++;
      if (want.data) data_seen++;
      if (want.last) frames_done++;
    endfunction
  endclass

endpackage

// File: verif/tb.sv
// Top-level testbench for oled_page_frame_buffer_top: stimulus, handshakes and final verdict.
module tb
  import opfb_pkg::*;
  import opfb_check_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Idle phases switch on the number of accepted input transactions.
  localparam int PHASE_B_AT   = 440;
  localparam int PHASE_C_AT   = 860;
  // Long receiver hold-off starts here; it lands in the middle of the full dump.
  localparam int HOLD_AT      = 950;
  localparam int LONG_HOLD    = 300;
  localparam int WARM_ITEMS   = 100;
  localparam int RANDOM_ITEMS = 1250;
  // Two-stage pipe; a handful of cycles covers anything still in flight.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = CMD_DRAW;
  logic [7:0] x = '0;
  logic [7:0] y = '0;
  logic       dot = 1'b0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_last;
  logic       busy_res;

  oled_byte_tracker tracker;
  int unsigned      items_sent = 0;
  int unsigned      cycle_count = 0;
  int               tx_idle_pct = 11;
  int               rx_idle_pct = 55;
  logic             hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int               hold_left = 0;

  oled_page_frame_buffer_top #(
    .PANEL_COLUMNS(PANEL_COLS),
    .PANEL_PAGES  (PANEL_PAGE_COUNT)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .x         (x),
    .y         (y),
    .dot       (dot),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .frame_last(frame_last),
    .busy_res  (busy_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("oled_page_frame_buffer_top regression: fail");
      $finish;
    end
  end

  // Result side. Random back-pressure, plus one long hold-off counted here so
  // the two-entry queue fills and in_ready drops while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Sample at the edge: values seen here are the ones the DUT acted on.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      tracker.match_panel_byte(out_valid, out_byte, is_data, frame_last, busy_res);
  end

  // One input transaction: optional idle gap, then hold valid until accepted.
  // The prediction is taken at the accepting edge so order matches the DUT.
  task automatic send_item(input logic [1:0] c, input logic [7:0] px,
                           input logic [7:0] py, input logic pdot);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    x        <= px;
    y        <= py;
    dot      <= pdot;
    do @(posedge clk); while (!in_ready);
    tracker.apply_command(c, px, py, pdot);
    items_sent++;
    // idle phases: sender light / receiver heavy, then swapped, then none
    if (items_sent == PHASE_B_AT) begin
      tx_idle_pct = 55;
      rx_idle_pct <= 11;
    end else if (items_sent == PHASE_C_AT) begin
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
    end else if (items_sent == HOLD_AT) begin
      hold_req <= 1'b1;
    end
  endtask

  // non-draw commands: coordinates and dot are don't-care, so randomize them
  task automatic send_cmd(input logic [1:0] c);
    send_item(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  // mostly on-panel pixels, some anywhere in the 8-bit range
  task automatic draw_random();
    logic [7:0] px;
    logic [7:0] py;
    px = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
                                      : 8'($urandom_range(0, 255));
    py = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 63))
                                      : 8'($urandom_range(0, 255));
    send_item(CMD_DRAW, px, py, 1'($urandom_range(0, 1)));
  endtask

  // Episodes: draw bursts, partial dumps with draws mixed in, stray ticks,
  // clears and restarts. Partial dumps keep the sequencer busy for a while.
  task automatic mixed_traffic(input int unsigned stop_at);
    int kind;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        repeat ($urandom_range(3, 15)) draw_random();
      end else if (kind < 75) begin
        send_cmd(CMD_START);
        repeat ($urandom_range(4, 60)) begin
          if ($urandom_range(0, 9) == 0) draw_random();
          else send_cmd(CMD_TICK);
        end
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4)) send_cmd(CMD_TICK);
      end else if (kind < 94) begin
        send_cmd(CMD_CLEAR);
      end else begin
        send_cmd(CMD_START);
      end
    end
  endtask

  initial begin
    int pick;
    tracker = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: tick with no dump, panel corners, off-panel draws, pixel
    // clear, a short dump with a draw showing up mid-dump, restart during a
    // dump, and a clear while the dump keeps running.
    send_cmd(CMD_TICK);
    send_item(CMD_DRAW, 8'd0, 8'd0, 1'b1);
    send_item(CMD_DRAW, 8'd127, 8'd63, 1'b1);
    send_item(CMD_DRAW, 8'd128, 8'd10, 1'b1);
    send_item(CMD_DRAW, 8'd3, 8'd64, 1'b1);
    send_item(CMD_DRAW, 8'd255, 8'd255, 1'b1);
    send_item(CMD_DRAW, 8'd127, 8'd63, 1'b0);
    send_item(CMD_DRAW, 8'd0, 8'd56, 1'b1);
    send_item(CMD_DRAW, 8'd0, 8'd7, 1'b1);
    send_cmd(CMD_START);
    repeat (4) send_cmd(CMD_TICK);
    send_item(CMD_DRAW, 8'd1, 8'd60, 1'b1);
    send_cmd(CMD_TICK);
    send_cmd(CMD_START);
    send_cmd(CMD_TICK);
    send_cmd(CMD_CLEAR);
    repeat (3) send_cmd(CMD_TICK);

    mixed_traffic(WARM_ITEMS);

    // One complete frame dump over a populated image: draws land in the
    // image while it streams out, rare clears wipe it, no restarts.
    repeat (40) draw_random();
    send_cmd(CMD_START);
    while (tracker.refresh_on) begin
      pick = $urandom_range(0, 999);
      if (pick < 70) draw_random();
      else if (pick < 71) send_cmd(CMD_CLEAR);
      else send_cmd(CMD_TICK);
    end

    mixed_traffic((items_sent + 40 > RANDOM_ITEMS) ? items_sent + 40 : RANDOM_ITEMS);
    in_valid <= 1'b0;

    while (tracker.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions: %0d draws (%0d off panel), %0d clears,",
             items_sent, tracker.cmd_count[CMD_DRAW], tracker.draws_off_panel,
             tracker.cmd_count[CMD_CLEAR]);
    $display("  %0d starts, %0d ticks; checked %0d panel bytes (%0d column data),",
             tracker.cmd_count[CMD_START], tracker.cmd_count[CMD_TICK],
             tracker.bytes_seen, tracker.data_seen);
    $display("  %0d complete frames, %0d mismatches",
             tracker.frames_done, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("oled_page_frame_buffer_top regression: pass");
    end else begin
      $display("oled_page_frame_buffer_top regression: fail");
    end
    $finish;
  end

endmodule
